// ===== rtl/ssr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg
// shared widths, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int CHANNELS_DEF     = 64;
  localparam int MAX_POINTS_DEF   = 256;
  localparam int SAMPLE_DEPTH_DEF = 4096;

  localparam int STEP_BASE = 13696;
  localparam int STEP_NUM  = STEP_BASE << 4;   // 219136

  localparam int POS_W  = 20;   // stored position, 1/32 sample units
  localparam int PX_W   = 21;   // working position width
  localparam int DIV_W  = 18;   // divider operand width
  localparam int WID_W  = 9;    // point count width
  localparam int WORD_W = 16;   // sample store word

  typedef struct packed {
    logic load_wr;
    logic req_latch;
    logic pos_load;
    logic div_step;
    logic step_load;
    logic div_trans;
    logic limit_zero;
    logic limit_load;
    logic issue;
    logic flush;
  } ssr_cmd_t;

  typedef struct packed {
    logic zero_w;
    logic err;
    logic div_done;
    logic num_pos;
    logic grp_end;
    logic req_end;
    logic out_free;
  } ssr_stat_t;

endpackage

// ===== rtl/sample_scope_point_renderer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_scope_point_renderer
// sample store plus per-channel playback stepper giving scope waveform points
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                       | moves
//  --------+-----------+-----------------------------+-----------------------
//  in_     | in        | in_valid / in_ready         | load word or render request
//  out_    | out       | out_valid / out_ready       | group of up to four points
//
//  a load request writes one store word. a render request first does its
//  setup (position fetch, up to two divisions in the shared serial divider) and
//  then issues its points in groups of four, at most one sample store read a point.
//  a request with zero points is taken and dropped, with no output; one in
//  error skips the divisions.
//  reset is synchronous active low; it clears the controller, the output
//  valid and the per-channel position valid bits, so every position reads 0.
//  a stalled output holds the request at its group boundary; the next request
//  is taken once the last group sits in the output register.
//  SAMPLE_DEPTH is a power of two; store addresses wrap modulo the depth.
//
module sample_scope_point_renderer import ssr_pkg::*; #(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic              in_trigger,
  input  logic [5:0]        in_channel,
  input  logic [15:0]       in_period,
  input  logic [8:0]        in_width,
  input  logic [11:0]       in_sample_base,
  input  logic [12:0]       in_sample_length,
  input  logic [12:0]       in_loop_start,
  input  logic [12:0]       in_loop_end,
  input  logic [1:0]        in_sample_flags,
  input  logic              in_sample_ok,
  input  logic [15:0]       in_load_word,
  // point channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] out_point_0,
  output logic signed [7:0] out_point_1,
  output logic signed [7:0] out_point_2,
  output logic signed [7:0] out_point_3,
  output logic [2:0]        out_points_valid,
  output logic              out_last
);

  ssr_cmd_t  cmd;
  ssr_stat_t stat;

  // sequencer: owns the request handshake and steps the datapath
  ssr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: stores, divider, position stepper and output register
  ssr_dp #(
    .CHANNELS     (CHANNELS),
    .MAX_POINTS   (MAX_POINTS),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_trigger       (in_trigger),
    .in_channel       (in_channel),
    .in_period        (in_period),
    .in_width         (in_width),
    .in_sample_base   (in_sample_base),
    .in_sample_length (in_sample_length),
    .in_loop_start    (in_loop_start),
    .in_loop_end      (in_loop_end),
    .in_sample_flags  (in_sample_flags),
    .in_sample_ok     (in_sample_ok),
    .in_load_word     (in_load_word),
    .out_point_0      (out_point_0),
    .out_point_1      (out_point_1),
    .out_point_2      (out_point_2),
    .out_point_3      (out_point_3),
    .out_points_valid (out_points_valid),
    .out_last         (out_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready)
  );

endmodule

// ===== rtl/ssr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ssr_ram #(
  parameter int W = 16,
  parameter int D = 256,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ssr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ssr_div #(
  parameter int W = 18
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     quo_r, quo_nxt;
  logic [W:0]       rem_r, rem_nxt;
  logic [W-1:0]     dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [W:0]       shifted;
  logic [W+1:0]     diff;

  assign shifted = {rem_r[W-1:0], quo_r[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};

  always_comb begin
    if (!diff[W+1]) begin
      rem_nxt = diff[W:0];
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted;
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/ssr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_ctrl
// request sequencer: load writes; renders: position fetch, up to two divisions, point loop, group output
// ----------------------------------------------------------------------------
module ssr_ctrl import ssr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_mode,
  output logic      in_ready,
  input  ssr_stat_t stat,
  output ssr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_DIV1,
    ST_NUM,
    ST_DIV2,
    ST_RUN,
    ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_mode) begin
            cmd.load_wr = 1'b1;
          end else if (!stat.zero_w) begin
            cmd.req_latch = 1'b1;
            state_nxt     = ST_POS;
          end
        end
      end
      ST_POS: begin
        cmd.pos_load = 1'b1;
        if (stat.err) begin
          state_nxt = ST_RUN;
        end else begin
          cmd.div_step = 1'b1;
          state_nxt    = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (stat.div_done) begin
          cmd.step_load = 1'b1;
          state_nxt     = ST_NUM;
        end
      end
      ST_NUM: begin
        if (stat.num_pos) begin
          cmd.div_trans = 1'b1;
          state_nxt     = ST_DIV2;
        end else begin
          cmd.limit_zero = 1'b1;
          state_nxt      = ST_RUN;
        end
      end
      ST_DIV2: begin
        if (stat.div_done) begin
          cmd.limit_load = 1'b1;
          state_nxt      = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (stat.grp_end) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = stat.req_end ? ST_IDLE : ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/ssr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_dp
// datapath: position and sample stores, divider, position stepper, output
// ----------------------------------------------------------------------------
module ssr_dp import ssr_pkg::*; #(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ssr_cmd_t          cmd,
  output ssr_stat_t         stat,
  input  logic              in_trigger,
  input  logic [5:0]        in_channel,
  input  logic [15:0]       in_period,
  input  logic [8:0]        in_width,
  input  logic [11:0]       in_sample_base,
  input  logic [12:0]       in_sample_length,
  input  logic [12:0]       in_loop_start,
  input  logic [12:0]       in_loop_end,
  input  logic [1:0]        in_sample_flags,
  input  logic              in_sample_ok,
  input  logic [15:0]       in_load_word,
  output logic signed [7:0] out_point_0,
  output logic signed [7:0] out_point_1,
  output logic signed [7:0] out_point_2,
  output logic signed [7:0] out_point_3,
  output logic [2:0]        out_points_valid,
  output logic              out_last,
  output logic              out_valid,
  input  logic              out_ready
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW = $clog2(SAMPLE_DEPTH);

  // request fields
  logic              trig_r, looped_r, wide_r, err_r;
  logic [CW-1:0]     ch_r;
  logic [15:0]       period_r;
  logic [11:0]       base_r;
  logic [12:0]       slen_r, lps_r, lpe_r;
  logic [WID_W-1:0]  w_r;

  logic [WID_W-1:0]  w_in;
  logic              err_in;

  assign w_in   = (in_width > WID_W'(MAX_POINTS)) ? WID_W'(MAX_POINTS) : in_width;
  assign err_in = !in_sample_ok || (in_period == 16'd0) || (in_sample_length == 13'd0) ||
                  ({3'b000, in_channel} >= 9'(CHANNELS));

  always_ff @(posedge clk) begin
    if (cmd.req_latch) begin
      trig_r   <= in_trigger;
      ch_r     <= CW'(in_channel);
      period_r <= in_period;
      base_r   <= in_sample_base;
      slen_r   <= in_sample_length;
      lps_r    <= in_loop_start;
      lpe_r    <= in_loop_end;
      looped_r <= in_sample_flags[0];
      wide_r   <= in_sample_flags[1];
      err_r    <= err_in;
      w_r      <= w_in;
    end
  end

  // channel positions, unwritten entries read as zero
  logic [CHANNELS-1:0] pos_vld_r;
  logic [POS_W-1:0]    pos_rd, pos_raw;
  logic [PX_W-1:0]     pos_r, pos_ld;
  logic                pos_we, last_d_r;

  assign pos_we = cmd.flush && last_d_r && !err_r;

  ssr_ram #(.W(POS_W), .D(CHANNELS)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (ch_r),
    .wdata (pos_r[POS_W-1:0]),
    .re    (cmd.req_latch),
    .raddr (CW'(in_channel)),
    .rdata (pos_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_vld_r <= '0;
    end else if (pos_we) begin
      pos_vld_r[ch_r] <= 1'b1;
    end
  end

  assign pos_raw = pos_vld_r[ch_r] ? pos_rd : '0;
  assign pos_ld  = (trig_r || (pos_raw[POS_W-1:5] >= {2'b00, slen_r})) ? '0
                                                                          : {1'b0, pos_raw};

  // shared divider for step and transition count
  logic [DIV_W-1:0] step_r, quot, dvd, dvs;
  logic             div_done;
  logic [DIV_W-1:0] target;
  logic [PX_W:0]    num;
  logic [WID_W-1:0] limit_r;

  assign target = looped_r ? {lps_r, 5'b00000} : {slen_r, 5'b00000};
  assign num    = {{(PX_W + 1 - DIV_W){1'b0}}, target} - {1'b0, pos_r};
  assign dvd    = cmd.div_step ? DIV_W'(STEP_NUM) : num[DIV_W-1:0];
  assign dvs    = cmd.div_step ? DIV_W'(period_r) : step_r;

  ssr_div #(.W(DIV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_step || cmd.div_trans),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.step_load) begin
      step_r <= quot;
    end
    if (cmd.limit_zero) begin
      limit_r <= '0;
    end else if (cmd.limit_load) begin
      limit_r <= (quot < {{(DIV_W - WID_W){1'b0}}, w_r}) ? quot[WID_W-1:0] : w_r;
    end
  end

  // point stepper
  logic [WID_W-1:0] idx_r, rem_r;
  logic             phase1, zero_pt;
  logic [PX_W-1:0]  p1, p2, p3, lpe_x, lps_x;

  assign phase1  = idx_r < limit_r;
  assign zero_pt = err_r || (!phase1 && !looped_r);
  assign lpe_x   = {3'b000, lpe_r, 5'b00000};
  assign lps_x   = {3'b000, lps_r, 5'b00000};
  assign p1      = pos_r + {3'b000, step_r};
  assign p2      = lps_x + (p1 - lpe_x);

  always_comb begin
    if (p1 >= lpe_x) begin
      p3 = (p2 >= lpe_x) ? lps_x : p2;
    end else begin
      p3 = p1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_load) begin
      pos_r <= pos_ld;
    end else if (cmd.issue && !zero_pt) begin
      pos_r <= phase1 ? p1 : p3;
    end
    if (cmd.req_latch) begin
      idx_r <= '0;
      rem_r <= w_in;
    end else if (cmd.issue) begin
      idx_r <= idx_r + 1'b1;
      rem_r <= rem_r - 1'b1;
    end
  end

  // sample store
  logic [16:0]       sa_sum;
  logic [WORD_W-1:0] st_rd;

  assign sa_sum = {5'b00000, base_r} + {1'b0, pos_r[PX_W-1:5]};

  ssr_ram #(.W(WORD_W), .D(SAMPLE_DEPTH)) u_store_ram (
    .clk   (clk),
    .we    (cmd.load_wr),
    .waddr (AW'(in_sample_base)),
    .wdata (in_load_word),
    .re    (cmd.issue && !zero_pt),
    .raddr (AW'(sa_sum)),
    .rdata (st_rd)
  );

  // group assembly
  logic            pend_r, zero_d_r;
  logic [1:0]      lane_d_r;
  logic [7:0]      byte_d;
  logic [7:0]      asm_r [4];
  logic [7:0]      grp   [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      lane_d_r <= idx_r[1:0];
      zero_d_r <= zero_pt;
      last_d_r <= (rem_r == WID_W'(1));
    end
  end

  assign byte_d = zero_d_r ? 8'h00 : (wide_r ? st_rd[15:8] : st_rd[7:0]);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      grp[i] = (lane_d_r == 2'(i)) ? byte_d : asm_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_latch || cmd.flush) begin
      for (int i = 0; i < 4; i++) begin
        asm_r[i] <= 8'h00;
      end
    end else if (pend_r) begin
      asm_r[lane_d_r] <= byte_d;
    end
  end

  // output register
  logic out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.flush) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      out_point_0      <= grp[0];
      out_point_1      <= grp[1];
      out_point_2      <= grp[2];
      out_point_3      <= grp[3];
      out_points_valid <= {1'b0, lane_d_r} + 3'd1;
      out_last         <= last_d_r;
    end
  end

  assign out_valid = out_vld_r;

  assign stat.zero_w   = (in_width == '0);
  assign stat.err      = err_r;
  assign stat.div_done = div_done;
  assign stat.num_pos  = !num[PX_W] && (num != '0) && (step_r != '0);
  assign stat.grp_end  = (idx_r[1:0] == 2'd3) || (rem_r == WID_W'(1));
  assign stat.req_end  = last_d_r;
  assign stat.out_free = !out_vld_r || out_ready;

endmodule

// ===== tb/tb_sample_scope_point_renderer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sample_scope_point_renderer
// loads the sample words each render will read, then drives directed and
// random requests; each point group but those of typed-in rows is checked
// against a local stepper that mirrors channel positions and store contents
// ----------------------------------------------------------------------------
module tb_sample_scope_point_renderer;
  import ssr_pkg::*;

  localparam int  NUM_CH     = CHANNELS_DEF;
  localparam int  NUM_PTS    = MAX_POINTS_DEF;
  localparam int  DEPTH      = SAMPLE_DEPTH_DEF;
  localparam int  RAND_ITEMS = 220;
  localparam int  DRAIN      = 400;
  localparam int  WIN_BASE   = DEPTH - 16;   // random renders read near here
  localparam longint CYCLE_LIMIT = 4000000;

  localparam bit MODE_LOAD   = 1'b0;
  localparam bit MODE_RENDER = 1'b1;
  localparam int FLAG_LOOP   = 1;
  localparam int FLAG_WIDE   = 2;

  // one request on the input channel
  typedef struct {
    bit          mode;
    bit          trigger;
    logic [5:0]  channel;
    logic [15:0] period;
    logic [8:0]  width;
    logic [11:0] base;
    logic [12:0] slen;
    logic [12:0] lstart;
    logic [12:0] lend;
    logic [1:0]  flags;
    bit          ok;
    logic [15:0] word;
    bit          silent;   // expected all-zero points, typed in directly
  } req_t;

  // one point group on the output channel
  typedef struct packed {
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] p3;
    logic [2:0] cnt;
    logic       last;
  } group_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_mode = 1'b0;
  logic              in_trigger = 1'b0;
  logic [5:0]        in_channel = '0;
  logic [15:0]       in_period = '0;
  logic [8:0]        in_width = '0;
  logic [11:0]       in_sample_base = '0;
  logic [12:0]       in_sample_length = '0;
  logic [12:0]       in_loop_start = '0;
  logic [12:0]       in_loop_end = '0;
  logic [1:0]        in_sample_flags = '0;
  logic              in_sample_ok = 1'b0;
  logic [15:0]       in_load_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [7:0] out_point_0, out_point_1, out_point_2, out_point_3;
  logic [2:0]        out_points_valid;
  logic              out_last;

  sample_scope_point_renderer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_trigger(in_trigger), .in_channel(in_channel),
    .in_period(in_period), .in_width(in_width), .in_sample_base(in_sample_base),
    .in_sample_length(in_sample_length), .in_loop_start(in_loop_start),
    .in_loop_end(in_loop_end), .in_sample_flags(in_sample_flags),
    .in_sample_ok(in_sample_ok), .in_load_word(in_load_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_point_0(out_point_0), .out_point_1(out_point_1),
    .out_point_2(out_point_2), .out_point_3(out_point_3),
    .out_points_valid(out_points_valid), .out_last(out_last)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mirrored block state
  logic [19:0] pos_mirror [NUM_CH];
  logic [15:0] store_mirror [DEPTH];
  bit          written [DEPTH];

  group_t pending_groups [$];
  int     need_addr [$];
  int     fail_count = 0;
  longint cycle_count = 0;
  bit     in_burst = 1'b0;    // stretches with no gaps on the request side
  bit     out_burst = 1'b0;   // stretches with no stalls on the point side

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // step one render request through the mirrored positions, queue its groups;
  // a dry pass only lists the unwritten store words the request would read
  task automatic predict_render(input req_t r, input bit dry);
    logic [7:0] pts [NUM_PTS];
    longint step, len, lps, lpe, pos, trans, lim;
    int     w, groups, first, cnt, i, addr;
    bit     looped, wide;
    logic [15:0] sw;
    group_t g;
    w = (r.width > NUM_PTS) ? NUM_PTS : int'(r.width);
    if (w == 0) return;
    for (i = 0; i < NUM_PTS; i++) pts[i] = 8'h00;
    if (r.ok && r.period != 0 && r.slen != 0) begin
      step   = STEP_NUM / longint'(r.period);
      len    = longint'(r.slen) * 32;
      lps    = longint'(r.lstart) * 32;
      lpe    = longint'(r.lend) * 32;
      looped = r.flags[0];
      wide   = r.flags[1];
      pos    = longint'(pos_mirror[r.channel]);
      if (r.trigger || (pos >> 5) >= longint'(r.slen)) pos = 0;
      if (step == 0) trans = 0;
      else trans = ((looped ? lps : len) - pos) / step;
      if (trans < 0) trans = 0;
      lim = (w < trans) ? w : trans;
      for (i = 0; i < w; i++) begin
        if (i >= lim && !looped) break;
        addr = int'((longint'(r.base) + (pos >> 5)) % DEPTH);
        if (dry) begin
          if (!written[addr]) need_addr.push_back(addr);
        end else begin
          sw     = store_mirror[addr];
          pts[i] = wide ? sw[15:8] : sw[7:0];
        end
        pos += step;
        if (i >= lim) begin
          // loop wrap, with the fallback for odd loop bounds
          if (pos >= lpe) pos = lps + pos - lpe;
          if (pos >= lpe) pos = lps;
        end
      end
      if (!dry) pos_mirror[r.channel] = pos[19:0];
    end
    if (dry) return;
    groups = (w + 3) / 4;
    for (i = 0; i < groups; i++) begin
      first  = i * 4;
      cnt    = (w - first > 4) ? 4 : w - first;
      g.p0   = pts[first];
      g.p1   = (cnt > 1) ? pts[first + 1] : 8'h00;
      g.p2   = (cnt > 2) ? pts[first + 2] : 8'h00;
      g.p3   = (cnt > 3) ? pts[first + 3] : 8'h00;
      g.cnt  = cnt[2:0];
      g.last = (i + 1 == groups);
      pending_groups.push_back(g);
    end
  endtask

  // error rows: zero points, position untouched
  task automatic queue_silent(input req_t r);
    int w, i, cnt;
    group_t g;
    w = (r.width > NUM_PTS) ? NUM_PTS : int'(r.width);
    for (i = 0; i < (w + 3) / 4; i++) begin
      cnt    = (w - i * 4 > 4) ? 4 : w - i * 4;
      g      = '0;
      g.cnt  = cnt[2:0];
      g.last = (i + 1 == (w + 3) / 4);
      pending_groups.push_back(g);
    end
  endtask

  // present one request and hold it until accepted; valid stays up across
  // back-to-back requests so it is never lowered and raised in one step
  task automatic send_request(input req_t r);
    int gap;
    gap = pick_gap(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= r.mode;
    in_trigger       <= r.trigger;
    in_channel       <= r.channel;
    in_period        <= r.period;
    in_width         <= r.width;
    in_sample_base   <= r.base;
    in_sample_length <= r.slen;
    in_loop_start    <= r.lstart;
    in_loop_end      <= r.lend;
    in_sample_flags  <= r.flags;
    in_sample_ok     <= r.ok;
    in_load_word     <= r.word;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge: update the mirror in request order
    if (r.mode == MODE_LOAD) begin
      store_mirror[r.base] = r.word;
      written[r.base]      = 1'b1;
    end
    else if (r.silent) queue_silent(r);
    else predict_render(r, 1'b0);
  endtask

  function automatic req_t mk_render(bit trig, int ch, int per, int wid, int base,
                                     int slen, int ls, int le, int flags, bit ok,
                                     bit silent);
    req_t r;
    r.mode = MODE_RENDER; r.trigger = trig; r.channel = 6'(ch); r.period = 16'(per);
    r.width = 9'(wid); r.base = 12'(base); r.slen = 13'(slen); r.lstart = 13'(ls);
    r.lend = 13'(le); r.flags = 2'(flags); r.ok = ok; r.word = 16'h0000;
    r.silent = silent;
    return r;
  endfunction

  function automatic req_t mk_load(int addr, int word);
    req_t r;
    r = mk_render(0, 0, 0, 0, addr, 0, 0, 0, 0, 0, 0);
    r.mode = MODE_LOAD; r.word = 16'(word);
    return r;
  endfunction

  // load every store word a render would read but nobody wrote, then send it
  task automatic issue_request(input req_t r);
    int a;
    if (r.mode == MODE_RENDER && !r.silent) begin
      need_addr.delete();
      predict_render(r, 1'b1);
      while (need_addr.size() != 0) begin
        a = need_addr.pop_front();
        if (!written[a]) send_request(mk_load(a, int'($urandom_range(0, 65535))));
      end
    end
    send_request(r);
  endtask

  function automatic req_t rand_request();
    req_t r;
    int k, ls, le, sl;
    k = $urandom_range(0, 99);
    if (k < 12) begin
      r = mk_load($urandom_range(0, DEPTH - 1), $urandom_range(0, 65535));
      return r;
    end
    sl = $urandom_range(1, 48);
    ls = $urandom_range(0, sl);
    le = $urandom_range(ls, sl);
    if ($urandom_range(0, 9) == 0) begin
      // odd loop bounds
      ls = $urandom_range(0, 48);
      le = $urandom_range(0, 48);
    end
    r = mk_render($urandom_range(0, 5) == 0, $urandom_range(0, 7), 0, 0,
                  (WIN_BASE + $urandom_range(0, 15)) % DEPTH, sl, ls, le,
                  $urandom_range(0, 3), $urandom_range(0, 19) != 0, 0);
    if ($urandom_range(0, 7) == 0) r.channel = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 3))
      0: r.period = 16'($urandom_range(1, 200));
      1: r.period = 16'($urandom_range(200, 2000));
      2: r.period = 16'($urandom_range(0, 65535));
      default: r.period = 16'($urandom_range(100, 900));
    endcase
    if ($urandom_range(0, 29) == 0) r.period = 0;
    if ($urandom_range(0, 29) == 0) r.slen = 0;
    r.width = ($urandom_range(0, 11) == 0) ? 9'($urandom_range(0, 511))
                                           : 9'($urandom_range(1, 40));
    return r;
  endfunction

  // point side: random stalls, with stretches of none
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) out_burst <= ~out_burst;
      stall = pick_gap(out_burst);
      if (stall == 0) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // compare every accepted group with the oldest pending one
  always @(posedge clk) begin
    group_t want, got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_point_0, out_point_1, out_point_2, out_point_3,
             out_points_valid, out_last};
      if (pending_groups.size() == 0) begin
        $display("%0t: unexpected group, actual %h", $time, got);
        fail_count++;
      end else begin
        want = pending_groups.pop_front();
        if (got !== want) begin
          $display("%0t: group mismatch, expected p=%h %h %h %h cnt=%0d last=%0d",
                   $time, want.p0, want.p1, want.p2, want.p3, want.cnt, want.last);
          $display("%0t:                 actual   p=%h %h %h %h cnt=%0d last=%0d",
                   $time, got.p0, got.p1, got.p2, got.p3, got.cnt, got.last);
          fail_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    req_t table_rows [$];
    int i;
    for (i = 0; i < NUM_CH; i++) pos_mirror[i] = '0;
    for (i = 0; i < DEPTH; i++) written[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: extremes, error cases, restarts and loop corners
    table_rows.push_back(mk_load(4095, 16'hffff));
    table_rows.push_back(mk_load(0, 16'h0000));
    table_rows.push_back(mk_load(1, 16'h8001));
    table_rows.push_back(mk_render(0, 0, 428, 0, 0, 100, 0, 100, 3, 1, 1));
    table_rows.push_back(mk_render(0, 1, 0, 8, 0, 100, 0, 100, 0, 1, 1));
    table_rows.push_back(mk_render(0, 1, 428, 9, 0, 100, 0, 100, 0, 0, 1));
    table_rows.push_back(mk_render(0, 1, 428, 5, 0, 0, 0, 100, 0, 1, 1));
    table_rows.push_back(mk_render(0, 2, 65535, 511, 4095, 4096, 0, 4096, 3, 1, 0));
    table_rows.push_back(mk_render(0, 2, 65535, 256, 4095, 4096, 0, 4096, 1, 1, 0));
    table_rows.push_back(mk_render(1, 2, 1, 1, 4095, 4096, 4096, 4096, 2, 1, 0));
    table_rows.push_back(mk_render(0, 3, 1, 7, 0, 4096, 4095, 4096, 1, 1, 0));
    table_rows.push_back(mk_render(0, 4, 428, 64, 0, 20, 2, 10, FLAG_LOOP, 1, 0));
    table_rows.push_back(mk_render(0, 4, 428, 64, 0, 20, 2, 10, FLAG_LOOP, 1, 0));
    table_rows.push_back(mk_render(1, 4, 428, 32, 0, 20, 2, 10, FLAG_WIDE, 1, 0));
    table_rows.push_back(mk_render(0, 4, 428, 32, 0, 20, 2, 10, 0, 1, 0));
    table_rows.push_back(mk_render(0, 5, 100, 40, 10, 30, 12, 3, FLAG_LOOP, 1, 0));
    table_rows.push_back(mk_render(0, 5, 100, 40, 10, 30, 8, 0, 3, 1, 0));
    table_rows.push_back(mk_render(0, 6, 3000, 2, 4000, 1, 0, 1, FLAG_LOOP, 1, 0));
    table_rows.push_back(mk_render(1, 63, 32768, 3, 4094, 4096, 4096, 4096, 1, 1, 0));
    table_rows.push_back(mk_render(1, 63, 32768, 0, 4094, 5, 4, 5, 3, 1, 1));
    table_rows.push_back(mk_render(0, 7, 5, 256, 100, 8191, 8191, 8191, 3, 1, 0));
    for (i = 0; i < table_rows.size(); i++) issue_request(table_rows[i]);

    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i % 30 == 0) in_burst = ($urandom_range(0, 2) == 0);
      issue_request(rand_request());
    end
    in_valid <= 1'b0;

    while (pending_groups.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending_groups.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
